// File: rtl/core/dltq_pkg.sv
// Package for the delta-list timer queue: payload structs, codes, cell link types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dltq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_FIND   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_FIRED     = 3'd0,
    KIND_INSERTED  = 3'd1,
    KIND_REJECTED  = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_FOUND     = 3'd4,
    KIND_NOT_FOUND = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] object_id;
    logic [15:0] function_id;
    logic [15:0] delay;
    logic [31:0] argument;
    logic [15:0] context_req;
    logic [15:0] elapsed;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] object_id_out;
    logic [15:0] function_id_out;
    logic [31:0] argument_out;
    logic [15:0] context_out;
    logic [15:0] remaining;
    logic        last;
  } rsp_t;

  // One stored event.
  typedef struct packed {
    logic [15:0] delta;
    logic [15:0] object_id;
    logic [15:0] function_id;
    logic [31:0] argument;
    logic [15:0] context_id;
  } entry_t;

  // Shift command broadcast to all cells.
  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_LEFT  = 2'd1,   // cell i takes cell i+1 (from position pos upward)
    SH_RIGHT = 2'd2    // cell i takes cell i-1 (above pos), pos takes new entry
  } shift_t;

  typedef struct packed {
    shift_t      shift;
    logic [IDX_W-1:0] pos;
    logic        wr_delta;      // write delta at wr_idx
    logic [IDX_W-1:0] wr_idx;
    logic [15:0] delta_val;
    entry_t      new_entry;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/dltq_cell.sv
// One storage cell of the timer queue chain; holds one entry.
// Depends on dltq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dltq_cell (
  input  wire logic              clk,
  input  wire logic [dltq_pkg::IDX_W-1:0] my_idx,
  input  wire dltq_pkg::cell_ctl_t ctl,
  input  wire dltq_pkg::entry_t  left_entry,
  input  wire dltq_pkg::entry_t  right_entry,
  output dltq_pkg::entry_t       entry
);
  import dltq_pkg::*;

  // Shift, load or patch the held entry.
  always_ff @(posedge clk) begin
    unique case (ctl.shift)
      SH_LEFT: begin
        if (my_idx >= ctl.pos) entry <= right_entry;
      end
      SH_RIGHT: begin
        if (my_idx > ctl.pos) entry <= left_entry;
        else if (my_idx == ctl.pos) entry <= ctl.new_entry;
      end
      default: begin
        if (ctl.wr_delta && my_idx == ctl.wr_idx) entry.delta <= ctl.delta_val;
      end
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/delta_list_timer_queue_core.sv
// Top level of the delta-list timer queue: sequencer over a chain of entry cells.
// Depends on dltq_pkg and dltq_cell.
`timescale 1ns / 1ps
`default_nettype none
// Insert, cancel and find walk the list one entry per cycle; the single result
// strobes once the walk ends and busy falls with it, but a cancel that shifts
// the list strobes in S_WALK and drops busy after S_SHIFT. A rejected insert
// strobes the cycle after accept, never raising busy. Tick checks the head in
// S_TICK, fires from S_FIRE (each result strobes the cycle after), then back in
// S_TICK writes any new head. Receiver cannot stall. Synchronous reset empties
// the queue; entry contents are left as they were and never read while invalid.
module delta_list_timer_queue_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire dltq_pkg::req_t  req,
  output logic                 busy,
  output logic                 result_valid,
  output dltq_pkg::rsp_t       result
);
  import dltq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WALK   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_TICK   = 5'b01000,
    S_FIRE   = 5'b10000
  } state_t;

  state_t state, state_next;
  req_t   cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [16:0] acc;        // remaining delay (insert) or running sum (cancel/find)
  logic signed [17:0] h;   // head balance during tick
  logic [5:0] fired;

  entry_t    ent [QUEUE_DEPTH];
  cell_ctl_t ctl;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_t l, r;
      if (g == 0) begin : g_l0
        assign l = ent[0];
      end else begin : g_l
        assign l = ent[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_rn
        assign r = ent[g];
      end else begin : g_r
        assign r = ent[g+1];
      end
      dltq_cell u_cell (
        .clk(clk), .my_idx(IDX_W'(g)), .ctl(ctl),
        .left_entry(l), .right_entry(r), .entry(ent[g])
      );
    end
  endgenerate

  wire [IDX_W-1:0] ix = idx[IDX_W-1:0];
  entry_t cur_ent;
  assign cur_ent = ent[ix];
  wire at_end = (idx == count);
  wire key_hit = cur_ent.object_id == cur.object_id && cur_ent.function_id == cur.function_id;
  wire [16:0] sum_next = acc + {1'b0, cur_ent.delta};
  wire [15:0] sum_sat = sum_next[16] ? SAT16 : sum_next[15:0];
  wire [15:0] dly_cl = (req.delay == 16'd0) ? 16'd1 : req.delay;
  wire [16:0] next_sum = {1'b0, ent[IDX_W'(idx + 1'b1)].delta} + {1'b0, cur_ent.delta};

  logic [CNT_W-1:0] count_next;
  logic rv_next;
  rsp_t res_next;
  logic [16:0] acc_next;
  logic signed [17:0] h_next;
  logic [CNT_W-1:0] idx_next;
  logic [5:0] fired_next;

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    acc_next   = acc;
    h_next     = h;
    fired_next = fired;
    rv_next    = 1'b0;
    res_next   = '0;
    ctl        = '0;
    ctl.shift  = SH_HOLD;
    ctl.new_entry = '{delta: acc[15:0], object_id: cur.object_id,
                      function_id: cur.function_id, argument: cur.argument,
                      context_id: cur.context_req};
    unique case (state)
      S_IDLE: ;
      S_WALK: begin
        if (cur.action == ACT_INSERT) begin
          // Walk until the new delay fits.
          if (at_end) begin
            state_next = S_SHIFT;
          end else if ({1'b0, cur_ent.delta} >= acc) begin
            ctl.wr_delta  = 1'b1;
            ctl.wr_idx    = ix;
            ctl.delta_val = cur_ent.delta - acc[15:0];
            state_next    = S_SHIFT;
          end else begin
            acc_next = acc - {1'b0, cur_ent.delta};
            idx_next = idx + 1'b1;
          end
        end else begin
          // Accumulate and compare keys for cancel/find.
          if (at_end) begin
            rv_next = 1'b1;
            res_next.kind = KIND_NOT_FOUND;
            res_next.object_id_out = cur.object_id;
            res_next.function_id_out = cur.function_id;
            res_next.last = 1'b1;
            state_next = S_IDLE;
          end else if (key_hit) begin
            rv_next = 1'b1;
            res_next.kind = (cur.action == ACT_CANCEL) ? KIND_CANCELLED : KIND_FOUND;
            res_next.object_id_out = cur_ent.object_id;
            res_next.function_id_out = cur_ent.function_id;
            res_next.argument_out = cur_ent.argument;
            res_next.context_out = cur_ent.context_id;
            res_next.remaining = sum_sat;
            res_next.last = 1'b1;
            if (cur.action == ACT_CANCEL) begin
              if (idx + 1'b1 < count) begin
                ctl.wr_delta  = 1'b1;
                ctl.wr_idx    = IDX_W'(idx + 1'b1);
                ctl.delta_val = next_sum[16] ? SAT16 : next_sum[15:0];
                state_next    = S_SHIFT;
              end else begin
                count_next = count - 1'b1;
                state_next = S_IDLE;
              end
            end else begin
              state_next = S_IDLE;
            end
          end else begin
            acc_next = {1'b0, sum_sat};
            idx_next = idx + 1'b1;
          end
        end
      end
      S_SHIFT: begin
        if (cur.action == ACT_INSERT) begin
          ctl.shift = SH_RIGHT;
          ctl.pos   = ix;
          count_next = count + 1'b1;
          rv_next = 1'b1;
          res_next.kind = KIND_INSERTED;
          res_next.object_id_out = cur.object_id;
          res_next.function_id_out = cur.function_id;
          res_next.remaining = (cur.delay == 16'd0) ? 16'd1 : cur.delay;
          res_next.last = 1'b1;
        end else begin
          ctl.shift = SH_LEFT;
          ctl.pos   = ix;
          count_next = count - 1'b1;
        end
        state_next = S_IDLE;
      end
      S_TICK: begin
        // Head reduced; decide whether it fires.
        if (count == '0) begin
          state_next = S_IDLE;
        end else if (h > 0 || fired == 6'd32) begin
          ctl.wr_delta  = 1'b1;
          ctl.wr_idx    = '0;
          ctl.delta_val = (h < 0) ? 16'd0 : (h > 18'sd65535 ? SAT16 : h[15:0]);
          state_next = S_IDLE;
        end else begin
          state_next = S_FIRE;
        end
      end
      S_FIRE: begin
        // Fire head, pop it, carry overdue into the next.
        rv_next = 1'b1;
        res_next.kind = KIND_FIRED;
        res_next.object_id_out = ent[0].object_id;
        res_next.function_id_out = ent[0].function_id;
        res_next.argument_out = ent[0].argument;
        res_next.context_out = ent[0].context_id;
        ctl.shift = SH_LEFT;
        ctl.pos   = '0;
        count_next = count - 1'b1;
        fired_next = fired + 1'b1;
        if (count > 1) h_next = $signed({2'b00, ent[1].delta}) + ((h < 0) ? h : 18'sd0);
        if (count == 1 || (h_next > 0) || fired_next == 6'd32) begin
          res_next.last = 1'b1;
          if (count > 1) state_next = S_TICK;
          else state_next = S_IDLE;
        end else begin
          state_next = S_FIRE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      result_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (state == S_IDLE && start) begin
        unique case (action_t'(req.action))
          ACT_INSERT: begin
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              result_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              result_valid <= 1'b0;
              state <= S_WALK;
            end
          end
          ACT_TICK: begin
            result_valid <= 1'b0;
            state <= (count == '0) ? S_IDLE : S_TICK;
          end
          default: begin
            result_valid <= 1'b0;
            state <= S_WALK;
          end
        endcase
      end else begin
        result_valid <= rv_next;
        state <= state_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur   <= req;
      idx   <= '0;
      fired <= '0;
      acc   <= (req.action == ACT_INSERT) ? {1'b0, dly_cl} : 17'd0;
      h     <= $signed({2'b00, ent[0].delta}) - $signed({2'b00, req.elapsed});
      if (req.action == ACT_INSERT && count == CNT_W'(QUEUE_DEPTH)) begin
        result <= '{kind: KIND_REJECTED, object_id_out: req.object_id,
                    function_id_out: req.function_id, argument_out: 32'd0,
                    context_out: 16'd0, remaining: 16'd0, last: 1'b1};
      end else begin
        result <= res_next;
      end
    end else begin
      result <= res_next;
      idx    <= idx_next;
      acc    <= acc_next;
      h      <= h_next;
      fired  <= fired_next;
    end
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire
